// ===== design/pnp_pkg.sv =====
package pnp_pkg;

  // Kind of result that the controller asks the datapath to register.
  typedef enum logic [1:0] {
    RES_PASS  = 2'd0,
    RES_PRIME = 2'd1,
    RES_OVF   = 2'd2
  } res_kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load_input;
    logic      next_cand;
    logic      start_div;
    logic      div_step;
    logic      next_div;
    logic      capture;
    res_kind_t kind;
    logic      out_taken;
  } pnp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic lt_two;
    logic sq_gt_n;
    logic div_last;
    logic rem_zero;
    logic cand_ovf;
    logic out_full;
  } pnp_stat_t;

endpackage

// ===== design/pnp_dp.sv =====
module pnp_dp import pnp_pkg::*; #(
  parameter int VALUE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  pnp_cmd_t                     cmd,
  output pnp_stat_t                    stat,
  input  logic signed [VALUE_BITS-1:0] value,
  output logic                         out_valid,
  output logic signed [VALUE_BITS-1:0] result_value,
  output logic                         was_prime,
  output logic                         overflow
);

  localparam int CW = $clog2(VALUE_BITS);
  localparam logic [CW-1:0] CNT_TOP = CW'(VALUE_BITS - 1);

  logic signed [VALUE_BITS-1:0] v_in;
  logic [VALUE_BITS-1:0] n;
  logic [VALUE_BITS-1:0] d;
  logic [VALUE_BITS-1:0] sq;
  logic [VALUE_BITS-1:0] rem;
  logic [CW-1:0]         cnt;
  logic [VALUE_BITS:0]   trial;
  logic [VALUE_BITS:0]   d_ext;
  logic [VALUE_BITS-1:0] rem_next;

  assign trial    = {rem, n[cnt]};
  assign d_ext    = {1'b0, d};
  assign rem_next = (trial >= d_ext) ? VALUE_BITS'(trial - d_ext) : trial[VALUE_BITS-1:0];

  assign stat.lt_two   = (v_in < VALUE_BITS'(signed'(2)));
  assign stat.sq_gt_n  = (sq > n);
  assign stat.div_last = (cnt == '0);
  assign stat.rem_zero = (rem == '0);
  assign stat.cand_ovf = n[VALUE_BITS-1];
  assign stat.out_full = out_valid;

  always_ff @(posedge clk) begin
    if (cmd.load_input) begin
      v_in <= value;
      n    <= value;
    end
    if (cmd.next_cand) begin
      n <= n + VALUE_BITS'(1);
    end
    if (cmd.load_input || cmd.next_cand) begin
      d  <= VALUE_BITS'(2);
      sq <= VALUE_BITS'(4);
    end else if (cmd.next_div) begin
      d  <= d + VALUE_BITS'(1);
      sq <= sq + {d[VALUE_BITS-2:0], 1'b1};
    end
    if (cmd.start_div) begin
      rem <= '0;
      cnt <= CNT_TOP;
    end else if (cmd.div_step) begin
      rem <= rem_next;
      cnt <= cnt - CW'(1);
    end
    if (cmd.capture) begin
      case (cmd.kind)
        RES_PASS: begin
          result_value <= v_in;
          was_prime    <= 1'b0;
          overflow     <= 1'b0;
        end
        RES_PRIME: begin
          result_value <= n;
          was_prime    <= 1'b1;
          overflow     <= 1'b0;
        end
        default: begin
          result_value <= '0;
          was_prime    <= 1'b1;
          overflow     <= 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.capture) begin
      out_valid <= 1'b1;
    end else if (cmd.out_taken) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== design/pnp_ctrl.sv =====
module pnp_ctrl import pnp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic      out_stall,
  input  pnp_stat_t stat,
  output pnp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TEST,
    S_DIV,
    S_REM,
    S_DONE
  } state_t;

  state_t    state, state_next;
  logic      first, first_next;
  res_kind_t kind, kind_next;
  logic      slot_free;

  assign in_stall  = (state != S_IDLE);
  assign slot_free = !stat.out_full || !out_stall;

  always_comb begin
    state_next    = state;
    first_next    = first;
    kind_next     = kind;
    cmd           = '0;
    cmd.kind      = kind;
    cmd.out_taken = stat.out_full && !out_stall;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_input = 1'b1;
          first_next     = 1'b1;
          state_next     = S_TEST;
        end
      end
      S_TEST: begin
        if (!first && stat.cand_ovf) begin
          kind_next  = RES_OVF;
          state_next = S_DONE;
        end else if (first && stat.lt_two) begin
          kind_next  = RES_PASS;
          state_next = S_DONE;
        end else if (stat.sq_gt_n) begin
          if (first) begin
            first_next    = 1'b0;
            cmd.next_cand = 1'b1;
          end else begin
            kind_next  = RES_PRIME;
            state_next = S_DONE;
          end
        end else begin
          cmd.start_div = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_REM;
        end
      end
      S_REM: begin
        if (stat.rem_zero) begin
          if (first) begin
            kind_next  = RES_PASS;
            state_next = S_DONE;
          end else begin
            cmd.next_cand = 1'b1;
            state_next    = S_TEST;
          end
        end else begin
          cmd.next_div = 1'b1;
          state_next   = S_TEST;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.capture = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      first <= 1'b0;
      kind  <= RES_PASS;
    end else begin
      state <= state_next;
      first <= first_next;
      kind  <= kind_next;
    end
  end

endmodule

// ===== design/prime_to_next_prime_core.sv =====
// Next-prime replacement. Each input beat carries one signed value. If the
// value is prime, the output beat carries the smallest prime above it with
// was_prime set; otherwise the value is passed through with was_prime clear.
// When no prime above a prime input fits the signed range, result_value is
// zero and overflow is set. Both channels use valid and stall; a beat moves
// on a rising edge with valid high and stall low.
// The block works on one beat at a time. Primality is decided by trial
// division. Each trial tests the divisor against the square bound, runs the
// bit-serial remainder unit and then acts on the remainder. An item is
// loaded, then goes through the trials of the input value and of each
// candidate up to the next prime, a decision and the registering of the
// result; values below two need no trial and even values above two need
// one. The next input beat is taken only after the result is registered.
// The result sits in an output register, so a new input beat is taken while
// a finished result is still waiting; if the receiver stalls, that register
// holds its beat and the next result waits in the controller until it frees.
// Synchronous reset returns the controller to idle and empties the output
// register; no result is lost or duplicated across stalls.
module prime_to_next_prime_core import pnp_pkg::*; #(
  parameter int VALUE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [VALUE_BITS-1:0] value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [VALUE_BITS-1:0] result_value,
  output logic                         was_prime,
  output logic                         overflow
);

  // Command and status between the sequencer and the trial-division datapath.
  pnp_cmd_t  cmd;
  pnp_stat_t stat;

  pnp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  pnp_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .value        (value),
    .out_valid    (out_valid),
    .result_value (result_value),
    .was_prime    (was_prime),
    .overflow     (overflow)
  );

endmodule
